// ----- src/fmm_pkg.sv -----
// Shared types, widths, register codes and the sine table for the FM NCO modulator.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package fmm_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int SHIFT_W    = 4;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 12;
   localparam int DEV_W      = 32;
   localparam int PERIOD_W   = 16;
   localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
   localparam int SCALED_W   = 20;
   localparam int MAG_W      = 20;
   localparam int SUM_W      = 40;
   localparam int LEVEL_W    = 23;
   localparam int DIVISOR_W  = PERIOD_W - 2;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
   localparam int OUT_W      = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   // register reset values
   localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd8;
   localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd4096;
   localparam logic [DEV_W-1:0]    DEV_RST    = 32'd0;
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1024;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // oscillator defaults
   localparam int PHASE_BITS_DEF    = 32;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int ROM_IDX_W         = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SHIFT     = 2'd0,
      CSR_GAIN      = 2'd1,
      CSR_DEVIATION = 2'd2,
      CSR_PERIOD    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_W-1:0]  shift_amount;
      logic [GAIN_W-1:0]   gain_q4_12;
      logic [DEV_W-1:0]    deviation_step;
      logic [PERIOD_W-1:0] level_period;
   } cfg_type;

   typedef struct packed {
      logic signed [SCALED_W-1:0] scaled;
      logic [MAG_W-1:0]           mag;
   } item_type;

   typedef struct packed {
      logic                 start;
      logic [SUM_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PHASE,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   localparam logic [7:0] QUARTER_WAVE [0:64] = '{
      8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd16,  8'd19,  8'd22,
      8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
      8'd49,  8'd51,  8'd54,  8'd57,  8'd60,  8'd63,  8'd65,  8'd68,
      8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,  8'd85,  8'd88,
      8'd90,  8'd92,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd104,
      8'd106, 8'd107, 8'd109, 8'd111, 8'd112, 8'd113, 8'd115, 8'd116,
      8'd117, 8'd118, 8'd120, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124,
      8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127,
      8'd127
   };

   // full-wave sine from the quarter-wave table; second half is negated
   function automatic logic signed [OUT_W-1:0] sine_at(input logic [ROM_IDX_W-1:0] idx);
      logic [6:0] k;
      logic [6:0] m;
      logic [7:0] q;
      k = idx[6:0];
      m = 7'(8'd128 - {1'b0, k});
      if (k <= 7'd64) begin
         q = QUARTER_WAVE[k];
      end else begin
         q = QUARTER_WAVE[m];
      end
      return idx[7] ? signed'(8'(-q)) : signed'(q);
   endfunction

endpackage

`default_nettype wire

// ----- src/fm_nco_modulator_with_level_meter.sv -----
// Top level of the FM NCO modulator with audio level meter: registers and wiring.
// Uses fmm_pkg and instantiates fmm_front, fmm_fifo, fmm_div and fmm_back.
`default_nettype none

// Each req transfer is one output tick carrying the held signed audio sample; each
// produces exactly one rsp transfer with I (cosine) and Q (sine) from a 256-entry
// sine table, plus a level report when the meter's down-counter is found at zero
// (the first tick after reset reports). The front end takes one sample per cycle
// into a four-deep queue while the queue has room; the back end steps each tick
// through pop and phase multiply, phase add, and table read into the result
// register, and a reporting tick adds the level division, one quotient bit per
// cycle over the 40-bit sum. The back end takes no new tick until the last one
// is loaded into the result register. Registers must be written through
// csr_we/csr_addr/csr_wdata only while no tick is in flight; the block does not enforce it.
module fm_nco_modulator_with_level_meter #(
   parameter int PHASE_BITS    = fmm_pkg::PHASE_BITS_DEF,
   parameter int TABLE_ENTRIES = fmm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [fmm_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] audio_sample
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] i_out, [15:8] q_out, [38:16] level_value, [39] zero
   output logic [fmm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,  // [0] level_valid
   input  wire logic                              csr_we,
   input  wire logic [fmm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [fmm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fmm_pkg::cfg_type                    cfg_ff;
   fmm_pkg::cfg_type                    cfg_in;
   logic                                push;
   fmm_pkg::item_type                   push_data;
   logic                                pop;
   fmm_pkg::item_type                   head;
   logic [fmm_pkg::FIFO_CNT_W-1:0]      fifo_count;
   fmm_pkg::div_req_type                div_req;
   fmm_pkg::div_rsp_type                div_rsp;
   logic signed [fmm_pkg::OUT_W-1:0]    i_out;
   logic signed [fmm_pkg::OUT_W-1:0]    q_out;
   logic [fmm_pkg::LEVEL_W-1:0]         level_value;
   logic                                level_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (fmm_pkg::csr_index_type'(csr_addr))
            fmm_pkg::CSR_SHIFT:
               cfg_in.shift_amount   = csr_wdata[fmm_pkg::SHIFT_W-1:0];
            fmm_pkg::CSR_GAIN:
               cfg_in.gain_q4_12     = csr_wdata[fmm_pkg::GAIN_W-1:0];
            fmm_pkg::CSR_DEVIATION:
               cfg_in.deviation_step = csr_wdata[fmm_pkg::DEV_W-1:0];
            fmm_pkg::CSR_PERIOD:
               cfg_in.level_period   = csr_wdata[fmm_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_amount   <= fmm_pkg::SHIFT_RST;
         cfg_ff.gain_q4_12     <= fmm_pkg::GAIN_RST;
         cfg_ff.deviation_step <= fmm_pkg::DEV_RST;
         cfg_ff.level_period   <= fmm_pkg::PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .fifo_count (fifo_count),
      .push       (push),
      .push_data  (push_data)
   );

   fmm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .count     (fifo_count)
   );

   fmm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fmm_back #(
      .PHASE_BITS    (PHASE_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .fifo_count  (fifo_count),
      .pop         (pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .i_out       (i_out),
      .q_out       (q_out),
      .level_value (level_value),
      .level_valid (level_valid)
   );

   assign rsp_tdata = {1'b0, level_value, q_out, i_out};
   assign rsp_tuser = level_valid;

endmodule

`default_nettype wire

// ----- src/fmm_front.sv -----
// Front end: takes audio ticks, shifts and scales them by the gain and saturates.
// Uses fmm_pkg; pushes finished items into fmm_fifo.
`default_nettype none

module fmm_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fmm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire fmm_pkg::cfg_type                    cfg,
   input  wire logic [fmm_pkg::FIFO_CNT_W-1:0]      fifo_count,
   output logic                                     push,
   output fmm_pkg::item_type                        push_data
);

   logic                                p1_valid_ff;
   logic                                p1_valid_in;
   logic signed [fmm_pkg::PROD_W-1:0]   prod_ff;
   logic signed [fmm_pkg::PROD_W-1:0]   prod_in;
   logic signed [fmm_pkg::SAMPLE_W-1:0] smp_sh;
   logic signed [fmm_pkg::GAIN_W:0]     gain_s;
   logic signed [fmm_pkg::PROD_W-1:0]   adj;
   logic signed [fmm_pkg::PROD_W-fmm_pkg::GAIN_FRAC-1:0] trunc;
   logic signed [fmm_pkg::SCALED_W-1:0] scaled;
   logic [fmm_pkg::FIFO_CNT_W:0]        used;
   logic                                accept;

   // count the item in the multiply stage as already queued
   assign used       = {1'b0, fifo_count} + (fmm_pkg::FIFO_CNT_W + 1)'(p1_valid_ff);
   assign req_tready = used < (fmm_pkg::FIFO_CNT_W + 1)'(fmm_pkg::FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;

   assign smp_sh  = $signed(req_tdata[fmm_pkg::SAMPLE_W-1:0]) >>> cfg.shift_amount;
   assign gain_s  = $signed({1'b0, cfg.gain_q4_12});
   assign prod_in = smp_sh * gain_s;
   assign p1_valid_in = accept;

   // round the product toward zero before dropping the fraction bits
   assign adj   = prod_ff + (prod_ff[fmm_pkg::PROD_W-1] ?
                  fmm_pkg::PROD_W'(4095) : fmm_pkg::PROD_W'(0));
   assign trunc = adj[fmm_pkg::PROD_W-1:fmm_pkg::GAIN_FRAC];

   always_comb begin
      if (trunc > 21'sd524287) begin
         scaled = 20'sh7FFFF;
      end else if (trunc < -21'sd524288) begin
         scaled = 20'sh80000;
      end else begin
         scaled = trunc[fmm_pkg::SCALED_W-1:0];
      end
   end

   assign push             = p1_valid_ff;
   assign push_data.scaled = scaled;
   assign push_data.mag    = scaled[fmm_pkg::SCALED_W-1] ? fmm_pkg::MAG_W'(-scaled) :
                             fmm_pkg::MAG_W'(scaled);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/fmm_fifo.sv -----
// Short queue of scaled samples between the front end and the back end.
// Uses fmm_pkg for the item type and depth.
`default_nettype none

module fmm_fifo (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire fmm_pkg::item_type              push_data,
   input  wire logic                           pop,
   output fmm_pkg::item_type                   pop_data,
   output logic [fmm_pkg::FIFO_CNT_W-1:0]      count
);

   fmm_pkg::item_type                  mem_ff [fmm_pkg::FIFO_DEPTH];
   logic [fmm_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff;
   logic [fmm_pkg::FIFO_PTR_W-1:0]     wr_ptr_in;
   logic [fmm_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [fmm_pkg::FIFO_PTR_W-1:0]     rd_ptr_in;
   logic [fmm_pkg::FIFO_CNT_W-1:0]     count_ff;
   logic [fmm_pkg::FIFO_CNT_W-1:0]     count_in;

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < fmm_pkg::FIFO_CNT_W'(fmm_pkg::FIFO_DEPTH))
      else $error("fifo push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("fifo pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fmm_pkg::FIFO_CNT_W'(fmm_pkg::FIFO_DEPTH))
      else $error("fifo count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != fmm_pkg::FIFO_CNT_W'(fmm_pkg::FIFO_DEPTH) |->
      fmm_pkg::FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[fmm_pkg::FIFO_PTR_W-1:0])
      else $error("fifo pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- src/fmm_div.sv -----
// Restoring divider for the level report: one quotient bit per cycle.
// Uses fmm_pkg for the request and response structs.
`default_nettype none

module fmm_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fmm_pkg::div_req_type req,
   output fmm_pkg::div_rsp_type      rsp
);

   logic [fmm_pkg::SUM_W-1:0]     dq_ff;
   logic [fmm_pkg::SUM_W-1:0]     dq_in;
   logic [fmm_pkg::DIVISOR_W-1:0] rem_ff;
   logic [fmm_pkg::DIVISOR_W-1:0] rem_in;
   logic [fmm_pkg::DIVISOR_W-1:0] dvs_ff;
   logic [fmm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [fmm_pkg::DIV_CNT_W-1:0] cnt_in;
   logic                          done_ff;
   logic                          done_in;
   logic [fmm_pkg::DIVISOR_W:0]   trial;
   logic [fmm_pkg::DIVISOR_W:0]   diff;
   logic                          ge;
   logic                          busy;

   assign busy  = cnt_ff != '0;
   assign trial = {rem_ff, dq_ff[fmm_pkg::SUM_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         dq_in  = req.dividend;
         rem_in = '0;
         cnt_in = fmm_pkg::DIV_CNT_W'(fmm_pkg::SUM_W);
      end else if (busy) begin
         // shift the dividend out on top, the quotient in at the bottom
         dq_in   = {dq_ff[fmm_pkg::SUM_W-2:0], ge};
         rem_in  = ge ? diff[fmm_pkg::DIVISOR_W-1:0] : trial[fmm_pkg::DIVISOR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == fmm_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (req.start) begin
         dvs_ff <= req.divisor;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dq_ff;

endmodule

`default_nettype wire

// ----- src/fmm_back.sv -----
// Back end: phase accumulator, sine lookup, level meter and the result register.
// Uses fmm_pkg; reads items from fmm_fifo and hands level sums to fmm_div.
`default_nettype none

module fmm_back #(
   parameter int PHASE_BITS    = fmm_pkg::PHASE_BITS_DEF,
   parameter int TABLE_ENTRIES = fmm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fmm_pkg::cfg_type               cfg,
   input  wire fmm_pkg::item_type              head,
   input  wire logic [fmm_pkg::FIFO_CNT_W-1:0] fifo_count,
   output logic                                pop,
   output fmm_pkg::div_req_type                div_req,
   input  wire fmm_pkg::div_rsp_type           div_rsp,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic signed [fmm_pkg::OUT_W-1:0]    i_out,
   output logic signed [fmm_pkg::OUT_W-1:0]    q_out,
   output logic [fmm_pkg::LEVEL_W-1:0]         level_value,
   output logic                                level_valid
);

   localparam int TB = $clog2(TABLE_ENTRIES);

   fmm_pkg::back_state_type             state_ff;
   fmm_pkg::back_state_type             state_in;
   logic [PHASE_BITS-1:0]               phase_ff;
   logic [PHASE_BITS-1:0]               mul_ff;
   logic [PHASE_BITS-1:0]               mul_in;
   logic [PHASE_BITS-1:0]               sc_ext;
   logic [fmm_pkg::SUM_W-1:0]           sum_ff;
   logic [fmm_pkg::SUM_W-1:0]           sum_with;
   logic [fmm_pkg::PERIOD_W-1:0]        cd_ff;
   logic                                report_ff;
   logic                                load_out;
   logic                                out_free;
   logic                                have_item;
   logic [TB-1:0]                       idx;
   logic [TB-1:0]                       cidx;
   logic [fmm_pkg::ROM_IDX_W-1:0]       rom_q;
   logic [fmm_pkg::ROM_IDX_W-1:0]       rom_i;
   logic [fmm_pkg::DIVISOR_W-1:0]       dvs_raw;
   logic [fmm_pkg::LEVEL_W-1:0]         level_sat;
   logic                                rsp_valid_ff;
   logic signed [fmm_pkg::OUT_W-1:0]    i_ff;
   logic signed [fmm_pkg::OUT_W-1:0]    q_ff;
   logic [fmm_pkg::LEVEL_W-1:0]         lvl_ff;
   logic                                lvv_ff;

   assign have_item = fifo_count != '0;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fmm_pkg::BK_IDLE: begin
            if (have_item) state_in = fmm_pkg::BK_PHASE;
         end
         fmm_pkg::BK_PHASE: begin
            state_in = report_ff ? fmm_pkg::BK_DIV : fmm_pkg::BK_EMIT;
         end
         fmm_pkg::BK_DIV: begin
            if (div_rsp.done) state_in = fmm_pkg::BK_EMIT;
         end
         fmm_pkg::BK_EMIT: begin
            if (out_free) state_in = fmm_pkg::BK_IDLE;
         end
         default: state_in = fmm_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         fmm_pkg::BK_IDLE:  pop = have_item;
         fmm_pkg::BK_PHASE: ;
         fmm_pkg::BK_DIV:   ;
         fmm_pkg::BK_EMIT:  load_out = out_free;
         default: ;
      endcase
   end

   // level sum includes this tick before a report
   assign sum_with = sum_ff + fmm_pkg::SUM_W'(head.mag);
   assign dvs_raw  = cfg.level_period[fmm_pkg::PERIOD_W-1:2];

   assign div_req.start    = pop && (cd_ff == '0);
   assign div_req.dividend = sum_with;
   assign div_req.divisor  = (dvs_raw == '0) ? fmm_pkg::DIVISOR_W'(1) : dvs_raw;

   // phase increment modulo the accumulator width
   assign sc_ext = PHASE_BITS'(head.scaled);
   assign mul_in = sc_ext * cfg.deviation_step[PHASE_BITS-1:0];

   assign idx   = phase_ff[PHASE_BITS-1 -: TB];
   assign cidx  = idx + TB'(TABLE_ENTRIES / 4);
   assign rom_q = fmm_pkg::ROM_IDX_W'({idx, {fmm_pkg::ROM_IDX_W{1'b0}}} >> TB);
   assign rom_i = fmm_pkg::ROM_IDX_W'({cidx, {fmm_pkg::ROM_IDX_W{1'b0}}} >> TB);

   assign level_sat = (|div_rsp.quotient[fmm_pkg::SUM_W-1:fmm_pkg::LEVEL_W]) ? '1 :
                      div_rsp.quotient[fmm_pkg::LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmm_pkg::BK_IDLE;
         phase_ff     <= '0;
         sum_ff       <= '0;
         cd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            if (cd_ff != '0) begin
               cd_ff  <= cd_ff - 1'b1;
               sum_ff <= sum_with;
            end else begin
               cd_ff  <= cfg.level_period;
               sum_ff <= '0;
            end
         end
         if (state_ff == fmm_pkg::BK_PHASE) begin
            phase_ff <= phase_ff + mul_ff;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mul_ff    <= mul_in;
         report_ff <= cd_ff == '0;
      end
      if (load_out) begin
         i_ff   <= fmm_pkg::sine_at(rom_i);
         q_ff   <= fmm_pkg::sine_at(rom_q);
         lvl_ff <= report_ff ? level_sat : '0;
         lvv_ff <= report_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign i_out       = i_ff;
   assign q_out       = q_ff;
   assign level_value = lvl_ff;
   assign level_valid = lvv_ff;

endmodule

`default_nettype wire
